FILE: rtl/trapezoidal_motion_profile_sampler_macros.svh
// Assertion macros for the trapezoidal motion profile sampler.
// Used by the top level; expects signals clock and reset in scope.
`ifndef TRAPEZOIDAL_MOTION_PROFILE_SAMPLER_MACROS_SVH
`define TRAPEZOIDAL_MOTION_PROFILE_SAMPLER_MACROS_SVH

// same-cycle implication
`define TMPS_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TMPS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tmps_pkg.sv
// Shared types and constants of the trapezoidal motion profile sampler.
// No dependencies.
package tmps_pkg;

   localparam logic [2:0] REG_PATH_LENGTH    = 3'd0;
   localparam logic [2:0] REG_MAX_VELOCITY   = 3'd1;
   localparam logic [2:0] REG_MAX_ACCEL      = 3'd2;
   localparam logic [2:0] REG_START_VELOCITY = 3'd3;
   localparam logic [2:0] REG_END_VELOCITY   = 3'd4;

   typedef enum logic [1:0] {
      PH_ACCEL  = 2'd0,
      PH_CRUISE = 2'd1,
      PH_DECEL  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      ST_START,
      ST_MUL_AL,
      ST_MUL_V0,
      ST_MUL_V1,
      ST_SQ_INIT,
      ST_SQRT,
      ST_VM,
      ST_MUL_VM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DC,
      ST_SUMS,
      ST_TOT,
      ST_IDLE
   } setup_state_type;

   typedef enum logic [2:0] {
      JOB_TA,
      JOB_DA,
      JOB_TD,
      JOB_DD,
      JOB_TC
   } job_type;

   typedef struct packed {
      logic [31:0] len;
      logic [23:0] max_vel;
      logic [23:0] accel;
      logic [23:0] v0;
      logic [23:0] v1;
   } cfg_type;

   typedef struct packed {
      logic [31:0] len;
      logic [23:0] accel;
      logic [23:0] v0;
      logic [23:0] v1;
      logic [23:0] vm;
      logic [63:0] ta;
      logic [63:0] tac;
      logic [63:0] ttot;
      logic [63:0] da;
      logic [63:0] dac;
   } derived_type;

endpackage

FILE: rtl/tmps_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on nothing.
module tmps_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic [63:0] quo,
   output logic        busy
);

   logic [63:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, q_ff[63]};
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quo  = q_ff;
   assign busy = busy_ff;

endmodule

FILE: rtl/tmps_setup.sv
// Profile setup sequencer: peak velocity by bitwise square root, phase times
// and distances by the shared divider. Depends on tmps_pkg and tmps_div.
module tmps_setup #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tmps_pkg::cfg_type     cfg,
   output tmps_pkg::derived_type drv,
   output logic                  busy
);

   tmps_pkg::setup_state_type state_ff, state_in;
   tmps_pkg::job_type         job_ff, job_in;

   logic [55:0] al_ff, al_in;
   logic [47:0] sq0_ff, sq0_in, sq1_ff, sq1_in, vv_ff, vv_in;
   logic [63:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic [23:0] vm_ff, vm_in;
   logic [63:0] ta_ff, ta_in, td_ff, td_in, da_ff, da_in, dd_ff, dd_in, tc_ff, tc_in;
   logic [63:0] dc_ff, dc_in, tac_ff, tac_in, dac_ff, dac_in, ttot_ff, ttot_in;

   logic [23:0] a_eff;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] rb;
   logic        div_start, div_busy, skip, job_last_dd, job_last_tc;
   logic [63:0] div_num, div_quo, res;
   logic [31:0] div_den;

   assign a_eff = (cfg.accel == 24'd0) ? 24'd1 : cfg.accel;
   assign mul_p = 64'(mul_a) * 64'(mul_b);
   assign rb    = r_ff + bit_ff;

   tmps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .busy  (div_busy)
   );

   always_comb begin
      skip    = 1'b0;
      div_num = '0;
      div_den = {8'd0, a_eff};
      case (job_ff)
         tmps_pkg::JOB_TA: begin
            skip    = !(vm_ff > cfg.v0);
            div_num = 64'(vm_ff - cfg.v0) << FRAC_BITS;
         end
         tmps_pkg::JOB_DA: begin
            skip    = !(vm_ff > cfg.v0);
            div_num = 64'(vv_ff - sq0_ff);
            div_den = {7'd0, a_eff, 1'b0};
         end
         tmps_pkg::JOB_TD: begin
            skip    = !(vm_ff > cfg.v1);
            div_num = 64'(vm_ff - cfg.v1) << FRAC_BITS;
         end
         tmps_pkg::JOB_DD: begin
            skip    = !(vm_ff > cfg.v1);
            div_num = 64'(vv_ff - sq1_ff);
            div_den = {7'd0, a_eff, 1'b0};
         end
         tmps_pkg::JOB_TC: begin
            skip    = (vm_ff == 24'd0);
            div_num = dc_ff << FRAC_BITS;
            div_den = {8'd0, vm_ff};
         end
         default: begin
            skip = 1'b1;
         end
      endcase
   end

   assign job_last_dd = (job_ff == tmps_pkg::JOB_DD);
   assign job_last_tc = (job_ff == tmps_pkg::JOB_TC);

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      al_in     = al_ff;
      sq0_in    = sq0_ff;
      sq1_in    = sq1_ff;
      vv_in     = vv_ff;
      x_in      = x_ff;
      r_in      = r_ff;
      bit_in    = bit_ff;
      vm_in     = vm_ff;
      ta_in     = ta_ff;
      td_in     = td_ff;
      da_in     = da_ff;
      dd_in     = dd_ff;
      tc_in     = tc_ff;
      dc_in     = dc_ff;
      tac_in    = tac_ff;
      dac_in    = dac_ff;
      ttot_in   = ttot_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      res       = '0;
      case (state_ff)
         tmps_pkg::ST_START: begin
            state_in = tmps_pkg::ST_MUL_AL;
         end
         tmps_pkg::ST_MUL_AL: begin
            mul_a    = {8'd0, a_eff};
            mul_b    = cfg.len;
            al_in    = mul_p[55:0];
            state_in = tmps_pkg::ST_MUL_V0;
         end
         tmps_pkg::ST_MUL_V0: begin
            mul_a    = {8'd0, cfg.v0};
            mul_b    = {8'd0, cfg.v0};
            sq0_in   = mul_p[47:0];
            state_in = tmps_pkg::ST_MUL_V1;
         end
         tmps_pkg::ST_MUL_V1: begin
            mul_a    = {8'd0, cfg.v1};
            mul_b    = {8'd0, cfg.v1};
            sq1_in   = mul_p[47:0];
            state_in = tmps_pkg::ST_SQ_INIT;
         end
         tmps_pkg::ST_SQ_INIT: begin
            x_in     = ({7'd0, al_ff, 1'b0} + 64'(sq0_ff) + 64'(sq1_ff)) >> 1;
            r_in     = '0;
            bit_in   = 64'd1 << 62;
            state_in = tmps_pkg::ST_SQRT;
         end
         tmps_pkg::ST_SQRT: begin
            if (x_ff >= rb) begin
               x_in = x_ff - rb;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = tmps_pkg::ST_VM;
            end
         end
         tmps_pkg::ST_VM: begin
            vm_in    = (r_ff < 64'(cfg.max_vel)) ? r_ff[23:0] : cfg.max_vel;
            state_in = tmps_pkg::ST_MUL_VM;
         end
         tmps_pkg::ST_MUL_VM: begin
            mul_a    = {8'd0, vm_ff};
            mul_b    = {8'd0, vm_ff};
            vv_in    = mul_p[47:0];
            job_in   = tmps_pkg::JOB_TA;
            state_in = tmps_pkg::ST_DIV_START;
         end
         tmps_pkg::ST_DIV_START, tmps_pkg::ST_DIV_WAIT: begin
            if ((state_ff == tmps_pkg::ST_DIV_START && skip) ||
                (state_ff == tmps_pkg::ST_DIV_WAIT && !div_busy)) begin
               res = (state_ff == tmps_pkg::ST_DIV_WAIT) ? div_quo : 64'd0;
               case (job_ff)
                  tmps_pkg::JOB_TA: ta_in = res;
                  tmps_pkg::JOB_DA: da_in = res;
                  tmps_pkg::JOB_TD: td_in = res;
                  tmps_pkg::JOB_DD: dd_in = res;
                  default:          tc_in = res;
               endcase
               if (job_last_dd) begin
                  state_in = tmps_pkg::ST_DC;
               end else if (job_last_tc) begin
                  state_in = tmps_pkg::ST_SUMS;
               end else begin
                  job_in   = tmps_pkg::job_type'(job_ff + 3'd1);
                  state_in = tmps_pkg::ST_DIV_START;
               end
            end else if (state_ff == tmps_pkg::ST_DIV_START) begin
               div_start = 1'b1;
               state_in  = tmps_pkg::ST_DIV_WAIT;
            end
         end
         tmps_pkg::ST_DC: begin
            if (64'(cfg.len) > da_ff && 64'(cfg.len) - da_ff > dd_ff) begin
               dc_in = 64'(cfg.len) - da_ff - dd_ff;
            end else begin
               dc_in = '0;
            end
            job_in   = tmps_pkg::JOB_TC;
            state_in = tmps_pkg::ST_DIV_START;
         end
         tmps_pkg::ST_SUMS: begin
            tac_in   = ta_ff + tc_ff;
            dac_in   = da_ff + dc_ff;
            state_in = tmps_pkg::ST_TOT;
         end
         tmps_pkg::ST_TOT: begin
            ttot_in  = tac_ff + td_ff;
            state_in = tmps_pkg::ST_IDLE;
         end
         default: begin
            state_in = tmps_pkg::ST_IDLE;
         end
      endcase
      if (start) begin
         state_in = tmps_pkg::ST_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmps_pkg::ST_START;
         job_ff   <= tmps_pkg::JOB_TA;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
      al_ff   <= al_in;
      sq0_ff  <= sq0_in;
      sq1_ff  <= sq1_in;
      vv_ff   <= vv_in;
      x_ff    <= x_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      vm_ff   <= vm_in;
      ta_ff   <= ta_in;
      td_ff   <= td_in;
      da_ff   <= da_in;
      dd_ff   <= dd_in;
      tc_ff   <= tc_in;
      dc_ff   <= dc_in;
      tac_ff  <= tac_in;
      dac_ff  <= dac_in;
      ttot_ff <= ttot_in;
   end

   assign busy      = (state_ff != tmps_pkg::ST_IDLE);
   assign drv.len   = cfg.len;
   assign drv.accel = a_eff;
   assign drv.v0    = cfg.v0;
   assign drv.v1    = cfg.v1;
   assign drv.vm    = vm_ff;
   assign drv.ta    = ta_ff;
   assign drv.tac   = tac_ff;
   assign drv.ttot  = ttot_ff;
   assign drv.da    = da_ff;
   assign drv.dac   = dac_ff;

endmodule

FILE: rtl/tmps_pipe.sv
// Five-stage sample pipeline: phase select, velocity multiply, velocity,
// distance multiply, distance add and saturate. Depends on tmps_pkg.
module tmps_pipe #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tmps_pkg::derived_type drv,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [31:0]           in_time,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [23:0]           out_vel,
   output logic [31:0]           out_dist,
   output tmps_pkg::phase_type   out_phase
);

   logic advance;

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   tmps_pkg::phase_type ph1_ff, ph1_in, ph2_ff, ph3_ff, ph4_ff, ph5_ff;
   logic [31:0]         u1_ff, u1_in, u2_ff, u3_ff;
   logic [23:0]         k1_ff, k1_in;
   logic [55:0]         m2_ff;
   logic [55:0]         p3_ff, p4_ff;
   logic [23:0]         vel3_ff, vel3_in, vel4_ff, vel5_ff;
   logic [24:0]         sum3_ff, sum3_in;
   logic [56:0]         m4_ff;
   logic [31:0]         dist5_ff;
   logic [63:0]         t64, dist_full, half;
   logic [55:0]         p_sh;

   assign advance  = !v5_ff || out_ready;
   assign in_ready = advance;
   assign t64      = {32'd0, in_time};

   always_comb begin
      if (t64 >= drv.ttot) begin
         ph1_in = tmps_pkg::PH_DONE;
         u1_in  = '0;
         k1_in  = '0;
      end else if (t64 < drv.ta) begin
         ph1_in = tmps_pkg::PH_ACCEL;
         u1_in  = in_time;
         k1_in  = drv.accel;
      end else if (t64 < drv.tac) begin
         ph1_in = tmps_pkg::PH_CRUISE;
         u1_in  = 32'(t64 - drv.ta);
         k1_in  = drv.vm;
      end else begin
         ph1_in = tmps_pkg::PH_DECEL;
         u1_in  = 32'(t64 - drv.tac);
         k1_in  = drv.accel;
      end
   end

   assign p_sh = m2_ff >> FRAC_BITS;

   always_comb begin
      sum3_in = '0;
      case (ph2_ff)
         tmps_pkg::PH_ACCEL: begin
            vel3_in = 24'(drv.v0 + p_sh[23:0]);
            sum3_in = 25'(drv.v0) + 25'(vel3_in);
         end
         tmps_pkg::PH_CRUISE: begin
            vel3_in = drv.vm;
         end
         tmps_pkg::PH_DECEL: begin
            vel3_in = 24'(drv.vm - p_sh[23:0]);
            sum3_in = 25'(drv.vm) + 25'(vel3_in);
         end
         default: begin
            vel3_in = drv.v1;
         end
      endcase
   end

   assign half = 64'(m4_ff) >> (FRAC_BITS + 1);

   always_comb begin
      case (ph4_ff)
         tmps_pkg::PH_ACCEL:  dist_full = half;
         tmps_pkg::PH_CRUISE: dist_full = drv.da + 64'(p4_ff);
         tmps_pkg::PH_DECEL:  dist_full = drv.dac + half;
         default:             dist_full = {32'd0, drv.len};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (advance) begin
         ph1_ff   <= ph1_in;
         u1_ff    <= u1_in;
         k1_ff    <= k1_in;
         ph2_ff   <= ph1_ff;
         u2_ff    <= u1_ff;
         m2_ff    <= 56'(u1_ff) * 56'(k1_ff);
         ph3_ff   <= ph2_ff;
         u3_ff    <= u2_ff;
         p3_ff    <= p_sh;
         vel3_ff  <= vel3_in;
         sum3_ff  <= sum3_in;
         ph4_ff   <= ph3_ff;
         p4_ff    <= p3_ff;
         vel4_ff  <= vel3_ff;
         m4_ff    <= 57'(u3_ff) * 57'(sum3_ff);
         ph5_ff   <= ph4_ff;
         vel5_ff  <= vel4_ff;
         dist5_ff <= (dist_full[63:32] != 32'd0) ? 32'hFFFF_FFFF : dist_full[31:0];
      end
   end

   assign out_valid = v5_ff;
   assign out_vel   = vel5_ff;
   assign out_dist  = dist5_ff;
   assign out_phase = ph5_ff;

endmodule

FILE: rtl/trapezoidal_motion_profile_sampler.sv
// Top level of the trapezoidal motion profile sampler: registers, setup, pipeline.
// Depends on tmps_pkg, tmps_setup, tmps_pipe and the assertion macro header.
//
//   channel   dir   beat
//   req_      in    sample_time
//   rsp_      out   velocity, distance, phase
//   csr_      in    register index, write data
//
// One sample per cycle through a five-stage pipeline while setup is idle and
// results are taken. After reset and after each register write the setup
// sequencer runs a square root and up to five divisions with req_tready low.
// A stalled result holds the whole pipeline.
`include "trapezoidal_motion_profile_sampler_macros.svh"
module trapezoidal_motion_profile_sampler #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_time
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [23:0] velocity, [55:24] distance
   output logic [1:0]  rsp_tuser,   // [1:0] phase
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   tmps_pkg::cfg_type     cfg_ff;
   tmps_pkg::derived_type drv;
   tmps_pkg::phase_type   phase;
   logic                  busy, pipe_ready, csr_fire;
   logic [23:0]           vel;
   logic [31:0]           dist_val;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.len     <= 32'd0;
         cfg_ff.max_vel <= 24'd65536;
         cfg_ff.accel   <= 24'd65536;
         cfg_ff.v0      <= 24'd0;
         cfg_ff.v1      <= 24'd0;
      end else if (csr_fire) begin
         case (csr_index)
            tmps_pkg::REG_PATH_LENGTH:    cfg_ff.len     <= csr_data;
            tmps_pkg::REG_MAX_VELOCITY:   cfg_ff.max_vel <= csr_data[23:0];
            tmps_pkg::REG_MAX_ACCEL:      cfg_ff.accel   <= csr_data[23:0];
            tmps_pkg::REG_START_VELOCITY: cfg_ff.v0      <= csr_data[23:0];
            tmps_pkg::REG_END_VELOCITY:   cfg_ff.v1      <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   tmps_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
      .clock (clock),
      .reset (reset),
      .start (csr_fire),
      .cfg   (cfg_ff),
      .drv   (drv),
      .busy  (busy)
   );

   tmps_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .drv       (drv),
      .in_valid  (req_tvalid && !busy),
      .in_ready  (pipe_ready),
      .in_time   (req_tdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_vel   (vel),
      .out_dist  (dist_val),
      .out_phase (phase)
   );

   assign req_tready = pipe_ready && !busy;
   assign rsp_tdata  = {dist_val, vel};
   assign rsp_tuser  = phase;

   `TMPS_CHECK_NEXT(a_csr_restarts_setup, csr_fire, busy, "setup not restarted by write")
   `TMPS_CHECK(a_no_beat_in_setup, req_tvalid && req_tready, !busy, "request during setup")
   `TMPS_CHECK(a_busy_rise_cause, $rose(busy), $past(csr_fire) || $past(reset), "stray setup")

endmodule
